// ===== rtl/core/uer_pkg.sv =====
// shared types and constants for the ultrasonic echo ranger
// command and result beat structs, status and register codes, divider constants
// no dependencies
package uer_pkg;

	localparam int unsigned SENSORS = 3;
	localparam logic [3:0] SENSOR_LIMIT = 4'(SENSORS);

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 8'd1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
	localparam logic [15:0] MAX_DISTANCE_RESET = 16'd6400;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [16:0] GAP_TICKS = 17'd4;
	localparam logic [16:0] PULSE_TICKS = 17'd10;

	// floor(w * 16 / 58) == (w * DIV_RECIP) >> DIV_SHIFT for any 16-bit w
	localparam logic [19:0] DIV_RECIP = 20'd578525;
	localparam int unsigned DIV_SHIFT = 21;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_ECHO = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_BAD_SENSOR = 3'd3;
	localparam logic [2:0] ST_BUSY = 3'd4;

	typedef struct packed {
		logic       kind;
		logic [2:0] sensor;
		logic       echo;
	} cmd_t;

	typedef struct packed {
		logic        trigger;
		logic [2:0]  active_sensor;
		logic        done_res;
		logic [2:0]  status;
		logic [15:0] distance_q4;
	} res_t;

endpackage

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// ultrasonic time-of-flight ranger: start/tick sequencer, echo width counter, distance
// uses uer_pkg for beat structs, codes and the constant divider
// a result beat is registered as its command beat is accepted, or held in the skid entry
// throughput: one command beat per cycle while cmd_stall is low; the result register plus a
// skid entry let a new beat in while an earlier result is still stalled
// distance path: one 16x20 multiply by a reciprocal and a clamp compare per beat
// reset: phase idle, trigger low, sensor 0, timeout 30000, clamp 6400, no result held
module ultrasonic_echo_ranger (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  uer_pkg::cmd_t                       cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output uer_pkg::res_t                       res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_GAP,
		PH_PULSE,
		PH_RISE,
		PH_WIDTH
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [16:0]   tick_q, tick_d;
	logic [2:0]    sensor_q, sensor_d;
	logic          trig_q, trig_d;
	logic [15:0]   timeout_q;
	logic [15:0]   max_dist_q;

	logic          res_valid_q;
	uer_pkg::res_t res_q;
	logic          skid_valid_q;
	uer_pkg::res_t skid_q;

	logic          acc;
	logic          take;
	logic [16:0]   tick_inc;
	logic [16:0]   timeout_x;
	logic [35:0]   prod;
	logic [14:0]   quot;
	logic [15:0]   dist_calc;
	logic          done;
	logic [2:0]    status;
	logic          use_max;
	logic          use_calc;
	uer_pkg::res_t r;

	assign cmd_stall = skid_valid_q;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign acc = cmd_valid && !skid_valid_q;
	assign take = res_valid_q && !res_stall;

	assign tick_inc = tick_q + 17'd1;
	assign timeout_x = {1'b0, timeout_q};

	// width * 16 / 58 via reciprocal, then clamp
	assign prod = 36'(tick_q[15:0]) * 36'(uer_pkg::DIV_RECIP);
	assign quot = prod[35:uer_pkg::DIV_SHIFT];
	assign dist_calc = ({1'b0, quot} > max_dist_q) ? max_dist_q : {1'b0, quot};

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		sensor_d = sensor_q;
		trig_d = trig_q;
		done = 1'b0;
		status = uer_pkg::ST_OK;
		use_max = 1'b0;
		use_calc = 1'b0;
		if (cmd.kind == uer_pkg::KIND_START) begin
			if ({1'b0, cmd.sensor} >= uer_pkg::SENSOR_LIMIT) begin
				done = 1'b1;
				status = uer_pkg::ST_BAD_SENSOR;
			end else if (phase_q != PH_IDLE) begin
				done = 1'b1;
				status = uer_pkg::ST_BUSY;
			end else begin
				sensor_d = cmd.sensor;
				phase_d = PH_GAP;
				tick_d = '0;
				trig_d = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_GAP: begin
					tick_d = tick_inc;
					if (tick_inc >= uer_pkg::GAP_TICKS) begin
						tick_d = '0;
						trig_d = 1'b1;
						phase_d = PH_PULSE;
					end
				end
				PH_PULSE: begin
					tick_d = tick_inc;
					if (tick_inc >= uer_pkg::PULSE_TICKS) begin
						tick_d = '0;
						trig_d = 1'b0;
						phase_d = PH_RISE;
					end
				end
				PH_RISE: begin
					if (!cmd.echo) begin
						tick_d = tick_inc;
						if (tick_inc > timeout_x) begin
							done = 1'b1;
							status = uer_pkg::ST_NO_ECHO;
							phase_d = PH_IDLE;
							tick_d = '0;
						end
					end else if (timeout_q == '0) begin
						done = 1'b1;
						status = uer_pkg::ST_TOO_LONG;
						use_max = 1'b1;
						phase_d = PH_IDLE;
						tick_d = '0;
					end else begin
						phase_d = PH_WIDTH;
						tick_d = 17'd1;
					end
				end
				PH_WIDTH: begin
					if (cmd.echo) begin
						tick_d = tick_inc;
						if (tick_inc > timeout_x) begin
							done = 1'b1;
							status = uer_pkg::ST_TOO_LONG;
							use_max = 1'b1;
							phase_d = PH_IDLE;
							tick_d = '0;
						end
					end else begin
						done = 1'b1;
						status = uer_pkg::ST_OK;
						use_calc = 1'b1;
						phase_d = PH_IDLE;
						tick_d = '0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		r.trigger = trig_d;
		r.active_sensor = sensor_d;
		r.done_res = done;
		r.status = status;
		if (use_max) begin
			r.distance_q4 = max_dist_q;
		end else if (use_calc) begin
			r.distance_q4 = dist_calc;
		end else begin
			r.distance_q4 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			sensor_q <= '0;
			trig_q <= 1'b0;
			timeout_q <= uer_pkg::TIMEOUT_RESET;
			max_dist_q <= uer_pkg::MAX_DISTANCE_RESET;
			res_valid_q <= 1'b0;
			res_q <= '0;
			skid_valid_q <= 1'b0;
			skid_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == uer_pkg::REG_TIMEOUT_TICKS) begin
					timeout_q <= cfg_data;
				end else if (cfg_index == uer_pkg::REG_MAX_DISTANCE) begin
					max_dist_q <= cfg_data;
				end
			end
			if (acc) begin
				phase_q <= phase_d;
				tick_q <= tick_d;
				sensor_q <= sensor_d;
				trig_q <= trig_d;
			end
			// result register with one skid entry behind it
			if (skid_valid_q) begin
				if (take) begin
					res_q <= skid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (acc) begin
				if (!res_valid_q || take) begin
					res_q <= r;
					res_valid_q <= 1'b1;
				end else begin
					skid_q <= r;
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== verif/uer_checker.sv =====
// scoreboard for the ultrasonic echo ranger: follows register writes and command beats,
// predicts every result beat and compares it field by field with what the block returns
// depends on uer_pkg for the beat structs, status codes and register indexes
module uer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  uer_pkg::cmd_t                   cmd,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  uer_pkg::res_t                   res,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatches,
	output int                              backlog,
	output int                              ranged,
	output int                              silent,
	output int                              clamped_long,
	output int                              refused
);
	timeunit 1ns;
	timeprecision 1ps;
	import uer_pkg::*;

	localparam int unsigned CM_DIV = 58;

	typedef enum logic [2:0] {
		P_IDLE,
		P_GAP,
		P_PULSE,
		P_RISE,
		P_WIDTH
	} ranger_phase_e;

	ranger_phase_e phase_q;
	logic [16:0]   ticks;
	logic [2:0]    sel;
	logic          trig;
	logic [15:0]   lim_reg;
	logic [15:0]   cap_reg;
	res_t          echo_reports[$];

	task automatic sequence_ranger(input cmd_t c, output res_t r);
		logic        fin;
		logic [2:0]  st;
		logic [15:0] range_q4;
		logic [31:0] q;
		fin = 1'b0;
		st = ST_OK;
		range_q4 = '0;
		if (c.kind == KIND_START) begin
			if ({1'b0, c.sensor} >= SENSOR_LIMIT) begin
				fin = 1'b1;
				st = ST_BAD_SENSOR;
			end else if (phase_q != P_IDLE) begin
				fin = 1'b1;
				st = ST_BUSY;
			end else begin
				sel = c.sensor;
				phase_q = P_GAP;
				ticks = '0;
				trig = 1'b0;
			end
		end else begin
			case (phase_q)
				P_IDLE: ;
				P_GAP: begin
					ticks++;
					if (ticks >= GAP_TICKS) begin
						ticks = '0;
						trig = 1'b1;
						phase_q = P_PULSE;
					end
				end
				P_PULSE: begin
					ticks++;
					if (ticks >= PULSE_TICKS) begin
						ticks = '0;
						trig = 1'b0;
						phase_q = P_RISE;
					end
				end
				P_RISE: begin
					if (!c.echo) begin
						ticks++;
						if (ticks > {1'b0, lim_reg}) begin
							fin = 1'b1;
							st = ST_NO_ECHO;
							phase_q = P_IDLE;
							ticks = '0;
						end
					end else if (lim_reg == '0) begin
						fin = 1'b1;
						st = ST_TOO_LONG;
						range_q4 = cap_reg;
						phase_q = P_IDLE;
						ticks = '0;
					end else begin
						phase_q = P_WIDTH;
						ticks = 17'd1;
					end
				end
				P_WIDTH: begin
					if (c.echo) begin
						ticks++;
						if (ticks > {1'b0, lim_reg}) begin
							fin = 1'b1;
							st = ST_TOO_LONG;
							range_q4 = cap_reg;
							phase_q = P_IDLE;
							ticks = '0;
						end
					end else begin
						q = ({15'd0, ticks} * 32'd16) / CM_DIV;
						range_q4 = (q > {16'd0, cap_reg}) ? cap_reg : q[15:0];
						fin = 1'b1;
						st = ST_OK;
						phase_q = P_IDLE;
						ticks = '0;
					end
				end
				default: phase_q = P_IDLE;
			endcase
		end
		r.trigger = trig;
		r.active_sensor = sel;
		r.done_res = fin;
		r.status = st;
		r.distance_q4 = range_q4;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		res_t next;
		if (!arst_n) begin
			phase_q = P_IDLE;
			ticks = '0;
			sel = '0;
			trig = 1'b0;
			lim_reg = TIMEOUT_RESET;
			cap_reg = MAX_DISTANCE_RESET;
			echo_reports.delete();
			mismatches = 0;
			ranged = 0;
			silent = 0;
			clamped_long = 0;
			refused = 0;
			backlog <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (echo_reports.size() == 0) begin
					$display("%0t ns: result beat, expected none actual %h", $time, res);
					mismatches++;
				end else begin
					want = echo_reports.pop_front();
					check_field("trigger", want.trigger, res.trigger);
					check_field("active_sensor", want.active_sensor, res.active_sensor);
					check_field("done_res", want.done_res, res.done_res);
					check_field("status", want.status, res.status);
					check_field("distance_q4", want.distance_q4, res.distance_q4);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT_TICKS: lim_reg = cfg_data;
					REG_MAX_DISTANCE: cap_reg = cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				sequence_ranger(cmd, next);
				echo_reports.push_back(next);
				if (next.done_res) begin
					case (next.status)
						ST_OK: ranged++;
						ST_NO_ECHO: silent++;
						ST_TOO_LONG: clamped_long++;
						default: refused++;
					endcase
				end
			end
			backlog <= echo_reports.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// top of the ultrasonic echo ranger testbench: clock, reset, command and register stimulus,
// result stall pattern and the verdict
// depends on uer_pkg, ultrasonic_echo_ranger and uer_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import uer_pkg::*;

	localparam int LONG_HOLD = 120;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_t                   cmd = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	res_t                   res;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic hold_req = 1'b0;
	int   mismatches, backlog, ranged, silent, clamped_long, refused;
	int   beats_sent = 0;
	int   idle_beats = 0;
	int   settings_used = 1;
	bit   bursty = 1'b0;
	int   burst_left = 0;

	ultrasonic_echo_ranger i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	uer_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.backlog     (backlog),
		.ranged      (ranged),
		.silent      (silent),
		.clamped_long(clamped_long),
		.refused     (refused)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : rx_pace
		int span;
		int odds;
		int hold_left;
		bit held;
		span = 0;
		odds = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_req && !held) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
				res_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					span = $urandom_range(1, 40);
					case ($urandom_range(0, 2))
						0: odds = 0;
						1: odds = 25;
						default: odds = 70;
					endcase
				end
				span--;
				res_stall <= ($urandom_range(0, 99) < odds);
			end
		end
	end

	task automatic pace();
		if (!bursty)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		cmd_valid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic send(input logic kind, input logic [2:0] sensor, input logic echo);
		cmd <= {kind, sensor, echo};
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		beats_sent++;
		pace();
	endtask

	// hold back until every result beat has come out
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic set_limits(input logic [15:0] lim, input logic [15:0] cap);
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_data <= lim;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MAX_DISTANCE;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic stray();
		if ($urandom_range(0, 11) == 0)
			send(KIND_START, 3'($urandom_range(0, 7)), 1'($urandom));
		if ($urandom_range(0, 29) == 0)
			settle();
	endtask

	task automatic range_once(input int lim);
		int rise;
		int wide;
		int n;
		logic [2:0] s;
		if ($urandom_range(0, 9) < 8)
			s = 3'($urandom_range(0, SENSORS - 1));
		else
			s = 3'($urandom_range(SENSORS, 7));
		send(KIND_START, s, 1'($urandom));
		if (s >= SENSORS)
			return;
		for (n = 0; n < 14; n++) begin
			stray();
			send(KIND_TICK, 3'($urandom), 1'($urandom));
		end
		rise = (lim <= 40) ? $urandom_range(0, lim + 1) : $urandom_range(0, 40);
		for (n = 0; n < rise; n++) begin
			stray();
			send(KIND_TICK, 3'($urandom), 1'b0);
		end
		if (rise > lim)
			return;
		if (lim <= 40)
			wide = $urandom_range(1, lim + 1);
		else if ($urandom_range(0, 9) == 0)
			wide = $urandom_range(1, 400);
		else
			wide = $urandom_range(1, 80);
		for (n = 0; n < wide; n++) begin
			stray();
			send(KIND_TICK, 3'($urandom), 1'b1);
		end
		if (wide > lim)
			return;
		send(KIND_TICK, 3'($urandom), 1'b0);
	endtask

	initial begin : stimulus
		int lims[6];
		int caps[6];
		int p;
		int n;
		int target;
		lims = '{30000, 1, 0, 20, 65535, 9};
		caps = '{6400, 65535, 7, 5, 0, 100};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle, bad sensors, busy, bad sensor over busy, one short echo
		send(KIND_TICK, 3'd7, 1'b1);
		send(KIND_START, 3'(SENSORS), 1'b0);
		send(KIND_START, 3'd7, 1'b1);
		send(KIND_START, 3'(SENSORS - 1), 1'b0);
		send(KIND_START, 3'd0, 1'b0);
		send(KIND_START, 3'd5, 1'b1);
		for (n = 0; n < 14; n++)
			send(KIND_TICK, 3'(n), 1'(n));
		send(KIND_TICK, 3'd0, 1'b0);
		send(KIND_TICK, 3'd7, 1'b1);
		send(KIND_TICK, 3'd2, 1'b1);
		send(KIND_TICK, 3'd5, 1'b0);

		for (p = 0; p < 6; p++) begin
			if (p != 0) begin
				settle();
				set_limits(16'(lims[p]), 16'(caps[p]));
			end
			bursty = (p % 2) == 1;
			if (p == 0)
				hold_req <= 1'b1;
			target = beats_sent - idle_beats + 100;
			while (beats_sent - idle_beats < target) begin
				range_once(lims[p]);
				if ($urandom_range(0, 3) == 0) begin
					send(KIND_TICK, 3'($urandom), 1'($urandom));
					idle_beats++;
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("drove %0d command beats under %0d register settings", beats_sent,
			settings_used);
		$display("%0d ranged, %0d without echo, %0d clamped long, %0d starts refused",
			ranged, silent, clamped_long, refused);
		if (mismatches == 0 && backlog == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
